FILE: rtl/ghp_pkg.sv
// ============================================================================
// ghp_pkg
// Shared widths, operation codes and default sizes of the generational
// handle pool.
// ============================================================================
package ghp_pkg;

   // Field widths of one request beat and one response beat.
   localparam int MODE_W = 2;
   localparam int HIDX_W = 10;
   localparam int GEN_W  = 32;

   // Operation codes carried in the mode field.
   localparam logic [MODE_W-1:0] MODE_ALLOC     = 2'd0;
   localparam logic [MODE_W-1:0] MODE_FREE      = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CHECK     = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RESET_ALL = 2'd3;

   // Default pool sizes.
   localparam int MAX_SLOTS_DEF     = 1024;
   localparam int INITIAL_SLOTS_DEF = 256;

endpackage

FILE: rtl/ghp_if.sv
// ============================================================================
// ghp_req_if / ghp_rsp_if
// Valid/ready channels that carry request and response beats of the pool.
// ============================================================================
interface ghp_req_if;
   logic                        valid;
   logic                        ready;
   logic [ghp_pkg::MODE_W-1:0]  mode;
   logic [ghp_pkg::HIDX_W-1:0]  handle_index;
   logic [ghp_pkg::GEN_W-1:0]   handle_generation;

   modport source (output valid, mode, handle_index, handle_generation, input ready);
   modport sink   (input valid, mode, handle_index, handle_generation, output ready);
endinterface

interface ghp_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        ok;
   logic [ghp_pkg::HIDX_W-1:0]  slot_index;
   logic [ghp_pkg::GEN_W-1:0]   slot_generation;

   modport source (output valid, ok, slot_index, slot_generation, input ready);
   modport sink   (input valid, ok, slot_index, slot_generation, output ready);
endinterface

FILE: rtl/generational_handle_pool_top.sv
// ============================================================================
// generational_handle_pool_top
// Slot allocator handing out (index, generation) handles, with a free-index
// stack and a generation word per slot kept in synchronous RAMs.
// ============================================================================
//
//   Channel   Dir   Beat contents                                Handshake
//   -------   ---   -------------------------------------------  ----------
//   req_bus   in    mode, handle_index, handle_generation        valid/ready
//   rsp_bus   out   ok, slot_index, slot_generation              valid/ready
//
// An allocate that pops the stack goes from acceptance to its response
// register through a stack read, a generation read and the update step; an
// allocate that grows the pool or fails, free, check and reset-all go from
// acceptance straight to the update step. One beat is in flight at a time:
// a new request is not taken until the update step of the last one is done.
// After reset the first min(INITIAL_SLOTS, MAX_SLOTS) generation entries are
// cleared, one entry per cycle, with req_bus.ready low until they are done.
// A new request is taken while a finished response still waits in the output
// register; only the update step stalls on a full output register.
//
module generational_handle_pool_top #(
   parameter int MAX_SLOTS     = ghp_pkg::MAX_SLOTS_DEF,
   parameter int INITIAL_SLOTS = ghp_pkg::INITIAL_SLOTS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ghp_req_if.sink   req_bus,
   ghp_rsp_if.source rsp_bus
);

   // Slot address width, count width (counts reach MAX_SLOTS itself) and a
   // common width in which handle indices and counts are compared.
   localparam int IW         = $clog2(MAX_SLOTS);
   localparam int CW         = $clog2(MAX_SLOTS + 1);
   localparam int XW         = (CW > ghp_pkg::HIDX_W) ? CW : ghp_pkg::HIDX_W;
   localparam int INIT_CLAMP = (INITIAL_SLOTS > MAX_SLOTS) ? MAX_SLOTS : INITIAL_SLOTS;
   localparam int GW         = ghp_pkg::GEN_W;

   // Sequencer states.
   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_POP   = 2'd2;
   localparam logic [1:0] ST_EXEC  = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [IW-1:0]               clr_ff, clr_in;

   // Latched request.
   logic [ghp_pkg::MODE_W-1:0]  mode_ff, mode_in;
   logic [ghp_pkg::HIDX_W-1:0]  hidx_ff, hidx_in;
   logic [GW-1:0]               hgen_ff, hgen_in;
   logic [IW-1:0]               slot_ff, slot_in;

   // Pool bookkeeping. The stack positions below fresh_ff still hold the
   // values of the last refill (refill_cap_ff-1-position) and are never
   // written; the stored generation is relative to epoch_ff, which counts
   // reset-all operations, so a reset-all only updates registers.
   logic [CW-1:0]               free_count_ff, free_count_in;
   logic [CW-1:0]               cap_ff, cap_in;
   logic [CW-1:0]               fresh_ff, fresh_in;
   logic [CW-1:0]               refill_cap_ff, refill_cap_in;
   logic [GW-1:0]               epoch_ff, epoch_in;

   // Response register.
   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_ok_ff, rsp_ok_in;
   logic [ghp_pkg::HIDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [GW-1:0]               rsp_gen_ff, rsp_gen_in;

   // RAM ports.
   logic                        stk_wr_en;
   logic [IW-1:0]               stk_wr_addr;
   logic [IW-1:0]               stk_wr_data;
   logic                        stk_rd_en;
   logic [IW-1:0]               stk_rd_addr;
   logic [IW-1:0]               stk_rd_data;
   logic                        gen_wr_en;
   logic [IW-1:0]               gen_wr_addr;
   logic [GW-1:0]               gen_wr_data;
   logic                        gen_rd_en;
   logic [IW-1:0]               gen_rd_addr;
   logic [GW-1:0]               gen_rd_data;

   // Helpers.
   logic                        req_accept;
   logic                        exec_fire;
   logic [XW-1:0]               req_idx_x;
   logic [XW-1:0]               hidx_x;
   logic [XW-1:0]               cap_x;
   logic [XW-1:0]               slot_x;
   logic [CW-1:0]               pop_pos;
   logic [CW-1:0]               implicit_slot;
   logic [IW-1:0]               pop_slot;
   logic [GW-1:0]               gen_actual;
   logic                        handle_match;

   // ------------------------------------------------------------------
   // Storage: free-index stack and per-slot generation words.
   // ------------------------------------------------------------------
   ghp_ram #(.WIDTH(IW), .DEPTH(MAX_SLOTS)) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   ghp_ram #(.WIDTH(GW), .DEPTH(MAX_SLOTS)) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_wr_en),
      .wr_addr (gen_wr_addr),
      .wr_data (gen_wr_data),
      .rd_en   (gen_rd_en),
      .rd_addr (gen_rd_addr),
      .rd_data (gen_rd_data)
   );

   // ------------------------------------------------------------------
   // Handshake and address generation.
   // ------------------------------------------------------------------
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;

   // The update step needs the output register free or draining this cycle.
   assign exec_fire = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_bus.ready);

   assign req_idx_x = XW'(req_bus.handle_index);
   assign hidx_x    = XW'(hidx_ff);
   assign cap_x     = XW'(cap_ff);
   assign slot_x    = XW'(slot_ff);

   // Top of stack. When the position lies in the untouched refill region its
   // value is known without the RAM.
   assign pop_pos       = free_count_ff - CW'(1);
   assign implicit_slot = refill_cap_ff - CW'(1) - pop_pos;
   assign pop_slot      = (pop_pos < fresh_ff) ? implicit_slot[IW-1:0] : stk_rd_data;

   assign stk_rd_en   = req_accept;
   assign stk_rd_addr = pop_pos[IW-1:0];

   // Free and check read the handle's generation at acceptance; an allocate
   // reads the popped slot's generation in the cycle after acceptance.
   assign gen_rd_en   = req_accept || (state_ff == ST_POP);
   assign gen_rd_addr = (state_ff == ST_POP) ? pop_slot : req_idx_x[IW-1:0];

   assign gen_actual   = gen_rd_data + epoch_ff;
   assign handle_match = (hidx_x < cap_x) && (gen_actual == hgen_ff);

   // ------------------------------------------------------------------
   // Sequencer and update step.
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      mode_in       = mode_ff;
      hidx_in       = hidx_ff;
      hgen_in       = hgen_ff;
      slot_in       = slot_ff;
      free_count_in = free_count_ff;
      cap_in        = cap_ff;
      fresh_in      = fresh_ff;
      refill_cap_in = refill_cap_ff;
      epoch_in      = epoch_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      rsp_ok_in     = rsp_ok_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_gen_in    = rsp_gen_ff;
      stk_wr_en     = 1'b0;
      stk_wr_addr   = free_count_ff[IW-1:0];
      stk_wr_data   = hidx_x[IW-1:0];
      gen_wr_en     = 1'b0;
      gen_wr_addr   = hidx_x[IW-1:0];
      gen_wr_data   = gen_rd_data + GW'(1);

      unique case (state_ff)
         ST_CLEAR: begin
            // Zero the generations of the initial slots after reset.
            gen_wr_en   = 1'b1;
            gen_wr_addr = clr_ff;
            gen_wr_data = '0;
            clr_in      = clr_ff + IW'(1);
            if (clr_ff == IW'(INIT_CLAMP - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               mode_in = req_bus.mode;
               hidx_in = req_bus.handle_index;
               hgen_in = req_bus.handle_generation;
               if (req_bus.mode == ghp_pkg::MODE_ALLOC && free_count_ff != '0) begin
                  state_in = ST_POP;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_POP: begin
            slot_in  = pop_slot;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (exec_fire) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_idx_in   = '0;
               rsp_gen_in   = '0;
               case (mode_ff)
                  ghp_pkg::MODE_ALLOC: begin
                     if (free_count_ff != '0) begin
                        free_count_in = free_count_ff - CW'(1);
                        rsp_ok_in     = 1'b1;
                        rsp_idx_in    = slot_x[ghp_pkg::HIDX_W-1:0];
                        rsp_gen_in    = gen_actual;
                     end else if (cap_ff < CW'(MAX_SLOTS)) begin
                        // Grow by one slot; its generation starts at zero.
                        gen_wr_en   = 1'b1;
                        gen_wr_addr = cap_ff[IW-1:0];
                        gen_wr_data = GW'(0) - epoch_ff;
                        cap_in      = cap_ff + CW'(1);
                        rsp_ok_in   = 1'b1;
                        rsp_idx_in  = cap_x[ghp_pkg::HIDX_W-1:0];
                     end
                  end
                  ghp_pkg::MODE_FREE: begin
                     if (handle_match) begin
                        rsp_ok_in = 1'b1;
                        gen_wr_en = 1'b1;
                        if (free_count_ff < CW'(MAX_SLOTS)) begin
                           stk_wr_en     = 1'b1;
                           free_count_in = free_count_ff + CW'(1);
                           fresh_in      = (free_count_ff < fresh_ff) ? free_count_ff
                                                                      : fresh_ff;
                        end
                     end
                  end
                  ghp_pkg::MODE_CHECK: begin
                     rsp_ok_in = handle_match;
                  end
                  default: begin
                     // Reset-all: every active generation advances and the
                     // stack is refilled with index 0 on top.
                     epoch_in      = epoch_ff + GW'(1);
                     free_count_in = cap_ff;
                     fresh_in      = cap_ff;
                     refill_cap_in = cap_ff;
                     rsp_ok_in     = 1'b1;
                  end
               endcase
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         free_count_ff <= CW'(INIT_CLAMP);
         cap_ff        <= CW'(INIT_CLAMP);
         fresh_ff      <= CW'(INIT_CLAMP);
         refill_cap_ff <= CW'(INIT_CLAMP);
         epoch_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         free_count_ff <= free_count_in;
         cap_ff        <= cap_in;
         fresh_ff      <= fresh_in;
         refill_cap_ff <= refill_cap_in;
         epoch_ff      <= epoch_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff    <= mode_in;
      hidx_ff    <= hidx_in;
      hgen_ff    <= hgen_in;
      slot_ff    <= slot_in;
      rsp_ok_ff  <= rsp_ok_in;
      rsp_idx_ff <= rsp_idx_in;
      rsp_gen_ff <= rsp_gen_in;
   end

   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.ok              = rsp_ok_ff;
   assign rsp_bus.slot_index      = rsp_idx_ff;
   assign rsp_bus.slot_generation = rsp_gen_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   a_counts_in_range: assert property (@(posedge clock) disable iff (reset)
      (free_count_ff <= CW'(MAX_SLOTS)) && (cap_ff <= CW'(MAX_SLOTS)))
      else $error("free count or capacity beyond the pool size");

   a_refill_region: assert property (@(posedge clock) disable iff (reset)
      (fresh_ff <= refill_cap_ff) && (refill_cap_ff <= cap_ff))
      else $error("refill region inconsistent with capacity");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> !req_bus.ready)
      else $error("second request taken while one is in flight");

   a_exec_responds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXEC && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("update step did not load the response register");

endmodule

FILE: rtl/ghp_ram.sv
// ============================================================================
// ghp_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ============================================================================
module ghp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      // Read data holds while no read is issued.
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: test/tb_top.sv
// ============================================================================
// tb_top
// Self-checking bench for the generational handle pool. A shadow copy of the
// pool state predicts the response to every accepted request. Directed
// corner cases are followed by mostly well-formed random traffic, with a fill to
// maximum capacity. Both channels idle and stall at random.
// ============================================================================
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MODE_W        = ghp_pkg::MODE_W;
   localparam int HIDX_W        = ghp_pkg::HIDX_W;
   localparam int GEN_W         = ghp_pkg::GEN_W;
   localparam int CLK_PERIOD    = 10;
   localparam int RESET_CYCLES  = 6;
   localparam int POOL_MAX      = ghp_pkg::MAX_SLOTS_DEF;
   localparam int POOL_INIT     = (ghp_pkg::INITIAL_SLOTS_DEF > ghp_pkg::MAX_SLOTS_DEF)
                                  ? ghp_pkg::MAX_SLOTS_DEF : ghp_pkg::INITIAL_SLOTS_DEF;
   localparam int RANDOM_ITEMS  = 1700;
   localparam int HOLD_AFTER    = 300;     // request beats sent before the long hold-off
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 2000;    // room for a stray response beat to show up

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [HIDX_W-1:0] handle_index;
      logic [GEN_W-1:0]  handle_generation;
   } pool_req_type;

   typedef struct packed {
      logic              ok;
      logic [HIDX_W-1:0] slot_index;
      logic [GEN_W-1:0]  slot_generation;
   } pool_rsp_type;

   // Shadow of the pool. Each accepted request updates the shadow state and
   // queues the response the block must produce; responses are checked in
   // order against that queue. The stimulus also reads the shadow to build
   // handles that are live, stale or out of range on purpose.
   class handle_pool_shadow_type;
      logic [GEN_W-1:0]  slot_gen [POOL_MAX];
      logic [HIDX_W-1:0] free_idx [POOL_MAX];
      int                free_depth;
      int                capacity;
      int                handed_out [$];   // slots allocated and not freed since
      pool_rsp_type      pending_rsp [$];
      int                errors;

      function new();
         int k;
         for (k = 0; k < POOL_MAX; k++) begin
            slot_gen[k] = '0;
            free_idx[k] = '0;
         end
         capacity = POOL_INIT;
         errors   = 0;
         refill();
      endfunction

      // Every active index goes back on the stack, index 0 on top.
      function void refill();
         int k;
         for (k = 0; k < capacity; k++) begin
            free_idx[k] = HIDX_W'(capacity - 1 - k);
         end
         free_depth = capacity;
      endfunction

      // Whether the slot is currently handed out is deliberately not looked at.
      function bit handle_live(int idx, logic [GEN_W-1:0] gen);
         return (idx < capacity) && (slot_gen[idx] == gen);
      endfunction

      function void note_request(pool_req_type rq);
         pool_rsp_type want;
         int           slot;
         int           idx;
         int           k;
         bit           granted;
         want    = '0;
         granted = 1'b0;
         slot    = 0;
         idx     = int'(rq.handle_index);
         case (rq.mode)
            ghp_pkg::MODE_ALLOC: begin
               if (free_depth > 0) begin
                  free_depth--;
                  slot    = int'(free_idx[free_depth]);
                  granted = 1'b1;
               end else if (capacity < POOL_MAX) begin
                  // Empty stack: the pool grows by one fresh slot.
                  slot           = capacity;
                  slot_gen[slot] = '0;
                  capacity++;
                  granted        = 1'b1;
               end
               if (granted) begin
                  want.ok              = 1'b1;
                  want.slot_index      = HIDX_W'(slot);
                  want.slot_generation = slot_gen[slot];
                  handed_out.push_back(slot);
               end
            end
            ghp_pkg::MODE_FREE: begin
               if (handle_live(idx, rq.handle_generation)) begin
                  want.ok       = 1'b1;
                  slot_gen[idx] = slot_gen[idx] + 1'b1;
                  // A push onto a full stack is dropped; the generation still moves.
                  if (free_depth < POOL_MAX) begin
                     free_idx[free_depth] = rq.handle_index;
                     free_depth++;
                  end
                  for (k = 0; k < handed_out.size(); k++) begin
                     if (handed_out[k] == idx) begin
                        handed_out.delete(k);
                        break;
                     end
                  end
               end
            end
            ghp_pkg::MODE_CHECK: begin
               want.ok = handle_live(idx, rq.handle_generation);
            end
            ghp_pkg::MODE_RESET_ALL: begin
               for (k = 0; k < capacity; k++) begin
                  slot_gen[k] = slot_gen[k] + 1'b1;
               end
               refill();
               handed_out.delete();
               want.ok = 1'b1;
            end
            default: ;
         endcase
         pending_rsp.push_back(want);
      endfunction

      function void check_response(pool_rsp_type got);
         pool_rsp_type want;
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: response beat with none outstanding: ok=%0b index=%0d gen=%08h",
                     $time, got.ok, got.slot_index, got.slot_generation);
            return;
         end
         want = pending_rsp.pop_front();
         if (got.ok !== want.ok) begin
            errors++;
            $display("%0t: ok mismatch, expected %0b, got %0b", $time, want.ok, got.ok);
         end
         if (got.slot_index !== want.slot_index) begin
            errors++;
            $display("%0t: slot_index mismatch, expected %0d, got %0d",
                     $time, want.slot_index, got.slot_index);
         end
         if (got.slot_generation !== want.slot_generation) begin
            errors++;
            $display("%0t: slot_generation mismatch, expected %08h, got %08h",
                     $time, want.slot_generation, got.slot_generation);
         end
      endfunction

      // Responses still owed at the end count as one failure.
      function int close_out();
         if (pending_rsp.size() != 0) begin
            errors++;
            $display("%0t: %0d response beats never arrived", $time, pending_rsp.size());
         end
         return errors;
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   ghp_req_if req_bus ();
   ghp_rsp_if rsp_bus ();

   handle_pool_shadow_type pool = new();

   int beats_sent  = 0;     // accepted request beats so far
   int burst_left  = 0;     // beats left in the current sender burst
   bit offering    = 1'b0;  // mirrors what was last scheduled onto req_bus.valid

   generational_handle_pool_top #(
      .MAX_SLOTS     (POOL_MAX),
      .INITIAL_SLOTS (ghp_pkg::INITIAL_SLOTS_DEF)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Hard stop in case the block hangs. The slowest legal run, every beat
   // under the longest sender gaps and receiver stalls, needs well under a
   // hundredth of this.
   initial begin : watchdog
      #100_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Response side back-pressure. The receiver switches between a few stall
   // patterns, each kept for a random stretch, from always ready to mostly
   // stalled. Once, after enough requests went out, it holds ready low for a
   // long stretch so the pool backs up and has to stall its request side.
   initial begin : rsp_backpressure
      int  stall_mode;
      int  mode_left;
      int  hold_left;
      bit  hold_done;
      bit  ready_next;
      stall_mode = 0;
      mode_left  = 0;
      hold_left  = 0;
      hold_done  = 1'b0;
      forever begin
         if (hold_left > 0) begin
            hold_left--;
            ready_next = 1'b0;
         end else if (!hold_done && beats_sent >= HOLD_AFTER) begin
            hold_done  = 1'b1;
            hold_left  = HOLD_CYCLES - 1;
            ready_next = 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left  = $urandom_range(20, 200);
            end
            mode_left--;
            case (stall_mode)
               0:       ready_next = 1'b1;
               1:       ready_next = 1'($urandom_range(0, 1));
               2:       ready_next = ($urandom_range(0, 3) == 0);
               default: ready_next = ($urandom_range(0, 7) != 0);
            endcase
         end
         rsp_bus.ready <= ready_next;
         @(posedge clock);
      end
   end

   // Every accepted response beat is checked against the oldest prediction.
   // Values are read right at the edge, so they are the ones the edge saw.
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         pool.check_response('{rsp_bus.ok, rsp_bus.slot_index, rsp_bus.slot_generation});
      end
   end

   // Offers one request beat, waits for its handshake, then feeds it to the
   // shadow. The sender runs in bursts; when a burst ends, valid drops for a
   // random gap, which is zero often enough to leave stretches with no idling.
   task automatic send_beat(input logic [MODE_W-1:0] op,
                            input logic [HIDX_W-1:0] idx,
                            input logic [GEN_W-1:0]  gen);
      int gap;
      req_bus.valid             <= 1'b1;
      req_bus.mode              <= op;
      req_bus.handle_index      <= idx;
      req_bus.handle_generation <= gen;
      offering = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      pool.note_request('{op, idx, gen});
      beats_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            offering = 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // One random request. Most are well formed: allocations, frees and checks
   // of handles that are live right now. The rest are stale handles, double
   // frees of slots already on the stack, random noise that is mostly out of
   // range, and the occasional reset-all, kept rare since it frees every slot.
   task automatic send_random_item();
      int                pick;
      int                slot;
      logic [MODE_W-1:0] op;
      pick = $urandom_range(0, 99);
      if (pool.handed_out.size() == 0 && pick >= 40 && pick < 83) pick = 0;
      op = $urandom_range(0, 1) ? ghp_pkg::MODE_FREE : ghp_pkg::MODE_CHECK;
      if (pick < 40) begin
         // Handle fields of an allocate are don't-care; fill them anyway.
         send_beat(ghp_pkg::MODE_ALLOC, HIDX_W'($urandom), $urandom);
      end else if (pick < 83) begin
         slot = pool.handed_out[$urandom_range(0, pool.handed_out.size() - 1)];
         if (pick < 65)
            send_beat(ghp_pkg::MODE_FREE, HIDX_W'(slot), pool.slot_gen[slot]);
         else if (pick < 75)
            send_beat(ghp_pkg::MODE_CHECK, HIDX_W'(slot), pool.slot_gen[slot]);
         else
            send_beat(op, HIDX_W'(slot), pool.slot_gen[slot] - GEN_W'($urandom_range(1, 3)));
      end else if (pick < 91) begin
         slot = $urandom_range(0, POOL_MAX - 1);
         send_beat(op, HIDX_W'(slot), $urandom_range(0, 1) ? pool.slot_gen[slot] : $urandom);
      end else if (pick < 97) begin
         // Live generation on any active slot, whether handed out or not.
         slot = $urandom_range(0, pool.capacity - 1);
         send_beat(op, HIDX_W'(slot), pool.slot_gen[slot]);
      end else begin
         send_beat(ghp_pkg::MODE_RESET_ALL, HIDX_W'($urandom), $urandom);
      end
   endtask

   initial begin : stimulus
      int drain;
      int target;
      int errors;
      req_bus.valid             <= 1'b0;
      req_bus.mode              <= ghp_pkg::MODE_ALLOC;
      req_bus.handle_index      <= '0;
      req_bus.handle_generation <= '0;
      reset                     <= 1'b1;
      burst_left = $urandom_range(1, 16);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Right after reset the pool has 256 active slots, all at
      // generation 0, and the first beats wait out the generation RAM clear.
      send_beat(ghp_pkg::MODE_CHECK, 10'd0, 32'd0);            // lowest slot, valid
      send_beat(ghp_pkg::MODE_CHECK, 10'd255, 32'd0);          // last active slot
      send_beat(ghp_pkg::MODE_CHECK, 10'd256, 32'd0);          // first index out of range
      send_beat(ghp_pkg::MODE_CHECK, 10'd1023, 32'hFFFF_FFFF); // top of both fields
      send_beat(ghp_pkg::MODE_FREE, 10'd1023, 32'd0);          // free out of range
      send_beat(ghp_pkg::MODE_ALLOC, 10'd0, 32'd0);            // slot 0 from the top
      send_beat(ghp_pkg::MODE_ALLOC, 10'd0, 32'd0);            // then slot 1
      send_beat(ghp_pkg::MODE_CHECK, 10'd0, 32'd1);            // generation from the future
      send_beat(ghp_pkg::MODE_FREE, 10'd0, 32'd0);             // proper free
      send_beat(ghp_pkg::MODE_FREE, 10'd0, 32'd0);             // stale free
      send_beat(ghp_pkg::MODE_FREE, 10'd0, 32'd1);             // free of a slot already free
      send_beat(ghp_pkg::MODE_ALLOC, 10'd0, 32'd0);            // slot 0 comes back ...
      send_beat(ghp_pkg::MODE_ALLOC, 10'd0, 32'd0);            // ... twice
      send_beat(ghp_pkg::MODE_FREE, 10'd1, 32'hFFFF_FFFF);     // wrong generation
      send_beat(ghp_pkg::MODE_RESET_ALL, 10'd0, 32'd0);
      send_beat(ghp_pkg::MODE_ALLOC, 10'd0, 32'd0);
      send_beat(ghp_pkg::MODE_CHECK, 10'd1, 32'd1);
      send_beat(ghp_pkg::MODE_CHECK, 10'd2, 32'd0);            // stale after reset-all
      send_beat(ghp_pkg::MODE_FREE, 10'd5, 32'd1);             // never handed out, still valid
      send_beat(ghp_pkg::MODE_ALLOC, 10'h3FF, 32'hFFFF_FFFF);  // ignored fields all ones
      send_beat(ghp_pkg::MODE_RESET_ALL, 10'h3FF, 32'hFFFF_FFFF);

      // Mixed traffic at the initial capacity; the long hold-off falls here.
      repeat (600) send_random_item();

      // Drain the stack and grow the pool to its maximum, then push past it.
      while (!(pool.capacity == POOL_MAX && pool.free_depth == 0))
         send_beat(ghp_pkg::MODE_ALLOC, HIDX_W'($urandom), $urandom);
      send_beat(ghp_pkg::MODE_ALLOC, 10'd0, 32'd0);            // pool full
      send_beat(ghp_pkg::MODE_ALLOC, 10'h3FF, 32'hFFFF_FFFF);  // still full
      send_beat(ghp_pkg::MODE_CHECK, 10'd1023, pool.slot_gen[1023]);

      // After reset-all every slot is on the stack, so freeing a free slot
      // with its live generation finds the stack full and drops the push.
      send_beat(ghp_pkg::MODE_RESET_ALL, 10'd0, 32'd0);
      send_beat(ghp_pkg::MODE_FREE, 10'd0, pool.slot_gen[0]);
      send_beat(ghp_pkg::MODE_FREE, 10'd1023, pool.slot_gen[1023]);
      send_beat(ghp_pkg::MODE_CHECK, 10'd0, pool.slot_gen[0]);
      send_beat(ghp_pkg::MODE_ALLOC, 10'd0, 32'd0);

      // Mixed traffic at full capacity.
      target = (beats_sent + 150 > RANDOM_ITEMS) ? beats_sent + 150 : RANDOM_ITEMS;
      while (beats_sent < target) send_random_item();

      if (offering) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
      end

      // Wait for the outstanding responses, then long enough for a stray
      // extra beat to show up.
      drain = 0;
      while (pool.pending_rsp.size() != 0 && drain < DRAIN_LIMIT) begin
         @(posedge clock);
         drain++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);

      errors = pool.close_out();
      if (errors == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
